// ----- rtl/core/rcent_pkg.sv -----
// ----------------------------------------------------------------------------
// rcent_pkg
// Shared constants for the row centroid core: field widths, the mark value,
// the size reset value, the configuration register indexes and the divider states.
// ----------------------------------------------------------------------------
package rcent_pkg;

  localparam int PIXEL_W     = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 4;
  localparam int CENTER_W    = 10;
  localparam int ROW_IDX_W   = 10;

  localparam logic [PIXEL_W-1:0]   MARK_VALUE       = 8'd255;
  localparam logic [CFG_W-1:0]     SIZE_RESET       = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_EMIT = 3'b100
  } div_state_t;

endpackage

// ----- rtl/core/rcent_front.sv -----
// ----------------------------------------------------------------------------
// rcent_front
// Pixel front end: holds the size registers, tracks column and row, and
// accumulates marked columns. At each row end with marks it pushes a job.
// ----------------------------------------------------------------------------
module rcent_front
  import rcent_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COL_W      = 10,
  parameter int CNT_W      = 11,
  parameter int SUM_W      = 20,
  parameter int ROW_W      = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   pixel,
  output logic                 job_valid,
  input  logic                 job_ready,
  output logic [SUM_W-1:0]     job_sum,
  output logic [CNT_W-1:0]     job_count,
  output logic [ROW_W-1:0]     job_row
);

  localparam int WCAP_W = $clog2(MAX_WIDTH + 1);
  localparam int HCAP_W = $clog2(MAX_HEIGHT + 1);
  localparam int WSZ_W  = (CFG_W > WCAP_W) ? CFG_W : WCAP_W;
  localparam int HSZ_W  = (CFG_W > HCAP_W) ? CFG_W : HCAP_W;
  localparam logic [WSZ_W-1:0] W_MAX = WSZ_W'(MAX_WIDTH);
  localparam logic [HSZ_W-1:0] H_MAX = HSZ_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic [SUM_W-1:0] column_sum;
  logic [CNT_W-1:0] marked_count;

  logic [WSZ_W-1:0] w_cfg, w_eff;
  logic [HSZ_W-1:0] h_cfg, h_eff;
  logic             row_end, row_wrap, marked, fire;
  logic [SUM_W-1:0] column_sum_next;
  logic [CNT_W-1:0] marked_count_next;

  // a size of zero acts as one, oversize saturates
  always_comb begin
    w_cfg = WSZ_W'(image_width);
    h_cfg = HSZ_W'(image_height);
    if (w_cfg == '0) begin
      w_eff = WSZ_W'(1);
    end else if (w_cfg > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg == '0) begin
      h_eff = HSZ_W'(1);
    end else if (h_cfg > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = h_cfg;
    end
  end

  assign row_end  = WSZ_W'(column_position) >= (w_eff - WSZ_W'(1));
  assign row_wrap = HSZ_W'(row_position) >= (h_eff - HSZ_W'(1));
  assign marked   = (pixel == MARK_VALUE);

  assign column_sum_next   = marked ? column_sum + SUM_W'(column_position) : column_sum;
  assign marked_count_next = marked ? marked_count + CNT_W'(1) : marked_count;

  // only a row end needs room in the queue
  assign in_ready  = !row_end || job_ready;
  assign fire      = in_valid && in_ready;
  assign job_valid = in_valid && row_end && (marked_count_next != '0);
  assign job_sum   = column_sum_next;
  assign job_count = marked_count_next;
  assign job_row   = row_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      column_sum      <= '0;
      marked_count    <= '0;
    end else if (fire) begin
      if (row_end) begin
        column_position <= '0;
        column_sum      <= '0;
        marked_count    <= '0;
        row_position    <= row_wrap ? '0 : row_position + ROW_W'(1);
      end else begin
        column_position <= column_position + COL_W'(1);
        column_sum      <= column_sum_next;
        marked_count    <= marked_count_next;
      end
    end
  end

endmodule

// ----- rtl/core/rcent_fifo.sv -----
// ----------------------------------------------------------------------------
// rcent_fifo
// Two-entry register queue between the front end and the divider.
// ----------------------------------------------------------------------------
module rcent_fifo #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;
  logic             push, pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/core/rcent_div.sv -----
// ----------------------------------------------------------------------------
// rcent_div
// Back end: restoring divider, one quotient bit per cycle, followed by the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module rcent_div
  import rcent_pkg::*;
#(
  parameter int CNT_W = 11,
  parameter int SUM_W = 20,
  parameter int ROW_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  logic [SUM_W-1:0]     job_sum,
  input  logic [CNT_W-1:0]     job_count,
  input  logic [ROW_W-1:0]     job_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CENTER_W-1:0]  center_column,
  output logic [ROW_IDX_W-1:0] row_index
);

  localparam int ITER_W = $clog2(SUM_W);

  div_state_t        state, state_next;
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [ROW_W-1:0]  row;
  logic [ITER_W-1:0] iter;

  logic [CNT_W:0]    trial;
  logic              take;
  logic [CNT_W-1:0]  rem_next;
  logic              emit;

  assign job_ready = (state == DIV_IDLE);
  assign trial     = {rem, quot[SUM_W-1]};
  assign take      = trial >= {1'b0, divisor};
  assign rem_next  = take ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
  assign emit      = (state == DIV_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (job_valid) state_next = DIV_RUN;
      DIV_RUN:  if (iter == '0) state_next = DIV_EMIT;
      DIV_EMIT: if (emit) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        quot    <= job_sum;
        rem     <= '0;
        divisor <= job_count;
        row     <= job_row;
        iter    <= ITER_W'(SUM_W - 1);
      end
      DIV_RUN: begin
        quot <= {quot[SUM_W-2:0], take};
        rem  <= rem_next;
        iter <= iter - ITER_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      center_column <= CENTER_W'(quot);
      row_index     <= ROW_IDX_W'(row);
    end
  end

endmodule

// ----- rtl/core/row_centroid_of_marked_pixels_core.sv -----
// ----------------------------------------------------------------------------
// row_centroid_of_marked_pixels_core
// Per-row mean column of pixels equal to 255 in a raster-order mask.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  cfg     | cfg_valid/cfg_ready, cfg_index, data | in
//  pixel   | in_valid/in_ready, pixel             | in
//  result  | out_valid/out_ready, center, row     | out
//
//  Pixels are taken one per cycle; a row end waits only while the two-entry
//  job queue is full.
//  The divider works through each row with marks one quotient bit per cycle,
//  overlapped with the next row's pixels.
//  Synchronous reset; cfg_ready is always high.
//  A stalled result holds in the output register while the front keeps going.
// ----------------------------------------------------------------------------
module row_centroid_of_marked_pixels_core
  import rcent_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIXEL_W-1:0]   pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CENTER_W-1:0]  center_column,
  output logic [ROW_IDX_W-1:0] row_index
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W = 2 * COL_W;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int JOB_W = SUM_W + CNT_W + ROW_W;

  logic             fj_valid, fj_ready;
  logic [SUM_W-1:0] fj_sum;
  logic [CNT_W-1:0] fj_count;
  logic [ROW_W-1:0] fj_row;

  logic             bj_valid, bj_ready;
  logic [JOB_W-1:0] bj_data;

  assign cfg_ready = 1'b1;

  rcent_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_W     (COL_W),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .ROW_W     (ROW_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pixel    (pixel),
    .job_valid(fj_valid),
    .job_ready(fj_ready),
    .job_sum  (fj_sum),
    .job_count(fj_count),
    .job_row  (fj_row)
  );

  rcent_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fj_valid),
    .wr_ready(fj_ready),
    .wr_data ({fj_sum, fj_count, fj_row}),
    .rd_valid(bj_valid),
    .rd_ready(bj_ready),
    .rd_data (bj_data)
  );

  rcent_div #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W),
    .ROW_W(ROW_W)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (bj_valid),
    .job_ready    (bj_ready),
    .job_sum      (bj_data[JOB_W-1 -: SUM_W]),
    .job_count    (bj_data[ROW_W +: CNT_W]),
    .job_row      (bj_data[ROW_W-1:0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .center_column(center_column),
    .row_index    (row_index)
  );

endmodule

// ----- rtl/core/rcent_checker.sv -----
// ----------------------------------------------------------------------------
// rcent_checker
// Port-level checks for the row centroid core, bound to the top level.
// ----------------------------------------------------------------------------
module rcent_checker
  import rcent_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CENTER_W-1:0]  center_column,
  input logic [ROW_IDX_W-1:0] row_index
);

  // a waiting result must not drop or change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(center_column) && $stable(row_index))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // a mean column lies inside the row, a row index inside the frame
  a_center_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(center_column) < MAX_WIDTH))
    else $error("center column beyond row width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(row_index) < MAX_HEIGHT))
    else $error("row index beyond frame height");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind row_centroid_of_marked_pixels_core rcent_checker #(
  .MAX_WIDTH (MAX_WIDTH),
  .MAX_HEIGHT(MAX_HEIGHT)
) u_rcent_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_ready    (cfg_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .center_column(center_column),
  .row_index    (row_index)
);

// ----- verif/row_centroid_of_marked_pixels_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_centroid_of_marked_pixels_core_test
// Streams mask pixels through the row centroid core under a range of image
// sizes and handshake pressure, computes each row's mean marked column in
// the bench and checks every result, in order, field by field.
// ----------------------------------------------------------------------------
module row_centroid_of_marked_pixels_core_test;
  import rcent_pkg::*;

  localparam int ROW_LIMIT      = 1024;
  localparam int FRAME_LIMIT    = 1024;
  localparam int SETTLE_CYCLES  = 64;   // divider + job queue + output reg, with margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 200;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_IMAGE_HEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct packed {
    logic [CENTER_W-1:0]  center;
    logic [ROW_IDX_W-1:0] row;
  } centroid_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CENTER_W-1:0]  center_column;
  logic [ROW_IDX_W-1:0] row_index;

  // bench copy of the row tracker
  logic [CFG_W-1:0]     width_reg = SIZE_RESET;
  logic [CFG_W-1:0]     height_reg = SIZE_RESET;
  logic [9:0]           col_at = '0;
  logic [ROW_IDX_W-1:0] row_at = '0;
  logic [18:0]          marked_col_sum = '0;
  logic [10:0]          marked_pixels = '0;

  logic [PIXEL_W-1:0] pending_pixels[$];
  centroid_t          expected_centroids[$];
  logic               pixel_fired = 1'b0;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatches = 0;
  int                 stalled_cycles = 0;

  always #1 clk = ~clk;

  row_centroid_of_marked_pixels_core #(
    .MAX_WIDTH(ROW_LIMIT),
    .MAX_HEIGHT(FRAME_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .center_column(center_column),
    .row_index(row_index)
  );

  function automatic int effective_size(logic [CFG_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return MARK_VALUE;
    if (pick < 55) return '0;
    if (pick < 65) return MARK_VALUE - 1'b1;
    return PIXEL_W'($urandom_range(255));
  endfunction

  task automatic set_flow(flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      FLOW_SENDER_GAPS: begin
        send_gap_pct = 67;
        recv_stall_pct = 0;
      end
      FLOW_RECEIVER_STALLS: begin
        send_gap_pct = 0;
        recv_stall_pct = 67;
      end
      default: begin
        send_gap_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every pending pixel is taken and every centroid has
  // come back, then let the core settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_centroids.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixel driver and result-side backpressure
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixel_fired) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        pixel    <= pending_pixels.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= $urandom_range(99) >= recv_stall_pct;
  end

  // monitor: tracks accepted requests, predicts centroids, checks results
  always @(posedge clk) begin : monitor
    centroid_t due;
    int        row_width;
    int        frame_height;
    pixel_fired <= !rst && in_valid && in_ready;
    if (rst) begin
      width_reg      = SIZE_RESET;
      height_reg     = SIZE_RESET;
      col_at         = '0;
      row_at         = '0;
      marked_col_sum = '0;
      marked_pixels  = '0;
      stalled_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        row_width    = effective_size(width_reg, ROW_LIMIT);
        frame_height = effective_size(height_reg, FRAME_LIMIT);
        if (pixel == MARK_VALUE) begin
          marked_col_sum = marked_col_sum + col_at;
          marked_pixels  = marked_pixels + 1'b1;
        end
        // a shrunk width ends the row at the very next pixel
        if (col_at + 1 >= row_width) begin
          if (marked_pixels != 0) begin
            due.center = marked_col_sum / marked_pixels;
            due.row    = row_at;
            expected_centroids.push_back(due);
          end
          col_at         = '0;
          marked_col_sum = '0;
          marked_pixels  = '0;
          if (row_at + 1 >= frame_height) row_at = '0;
          else row_at = row_at + 1'b1;
        end else begin
          col_at = col_at + 1'b1;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_centroids.size() == 0) begin
          $display("%0t: unexpected result center_column=%0d row_index=%0d",
                   $time, center_column, row_index);
          mismatches++;
        end else begin
          due = expected_centroids.pop_front();
          if (center_column !== due.center) begin
            $display("%0t: center_column expected %0d, got %0d",
                     $time, due.center, center_column);
            mismatches++;
          end
          if (row_index !== due.row) begin
            $display("%0t: row_index expected %0d, got %0d", $time, due.row, row_index);
            mismatches++;
          end
        end
      end

      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("row_centroid_of_marked_pixels_core_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int               phase;
    int               pick;
    int               rows;
    int               style;
    int               row_width;
    int               random_pixels_sent;
    logic [CFG_W-1:0] size_val;
    phase = 3;
    random_pixels_sent = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_flow(FLOW_FREE);
    // zero sizes act as one: every pixel is a full row and a full frame
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    pending_pixels = '{8'd255, 8'd0, 8'd254, 8'd255};
    wait_idle();

    // small frame, including a row with no marks and a frame wrap
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    pending_pixels = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd127};
    wait_idle();

    // writes to unused indexes must change nothing
    write_reg(REG_SPARE_FIRST, 11'd5);
    write_reg(REG_SPARE_LAST, '1);
    pending_pixels = '{8'd1, 8'd254, 8'd255};
    wait_idle();

    // oversize width, then shrink it under the current column
    write_reg(REG_IMAGE_WIDTH, '1);
    pending_pixels = '{8'd255, 8'd0, 8'd255};
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    pending_pixels = '{8'd255, 8'd0, 8'd255};
    wait_idle();

    // shrink the height past the current row
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, 11'd4);
    pending_pixels = '{8'd255, 8'd0, 8'd255};
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    pending_pixels = '{8'd255, 8'd255};
    wait_idle();

    // one full-width row marked only in its last column; oversize height
    set_flow(FLOW_SENDER_GAPS);
    write_reg(REG_IMAGE_WIDTH, CFG_W'(ROW_LIMIT));
    write_reg(REG_IMAGE_HEIGHT, '1);
    for (int c = 0; c < ROW_LIMIT; c++)
      pending_pixels.push_back(c == ROW_LIMIT - 1 ? MARK_VALUE : PIXEL_W'($urandom_range(254)));
    wait_idle();

    // one-pixel rows through a short frame and past its wrap
    set_flow(FLOW_RECEIVER_STALLS);
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, 11'd48);
    repeat (56)
      pending_pixels.push_back($urandom_range(9) != 0 ? MARK_VALUE
                                                      : PIXEL_W'($urandom_range(254)));
    wait_idle();

    while (random_pixels_sent < RANDOM_PIXELS) begin
      set_flow(flow_mode_t'(phase % 4));
      phase++;

      pick = $urandom_range(99);
      if (pick < 50) size_val = CFG_W'($urandom_range(8, 1));
      else if (pick < 80) size_val = CFG_W'($urandom_range(40, 9));
      else if (pick < 90) size_val = CFG_W'($urandom_range(120, 41));
      else size_val = '0;
      write_reg(REG_IMAGE_WIDTH, size_val);
      row_width = effective_size(size_val, ROW_LIMIT);

      pick = $urandom_range(99);
      if (pick < 55) size_val = CFG_W'($urandom_range(4, 1));
      else if (pick < 80) size_val = CFG_W'($urandom_range(30, 5));
      else if (pick < 88) size_val = '0;
      else if (pick < 94) size_val = CFG_W'(FRAME_LIMIT);
      else size_val = CFG_W'($urandom_range(2047, FRAME_LIMIT + 1));
      write_reg(REG_IMAGE_HEIGHT, size_val);

      if ($urandom_range(4) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  CFG_W'($urandom_range(2047)));

      rows = $urandom_range(12, 2);
      repeat (rows) begin
        style = $urandom_range(99);
        repeat (row_width)
          pending_pixels.push_back(style < 15 ? PIXEL_W'($urandom_range(254)) :
                                   style < 25 ? MARK_VALUE : random_pixel());
      end
      // ragged tail: the next size change can land mid-row
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(row_width - 1)) pending_pixels.push_back(random_pixel());
      random_pixels_sent += pending_pixels.size();
      wait_idle();
    end

    if (mismatches == 0 && expected_centroids.size() == 0) begin
      $display("row_centroid_of_marked_pixels_core_test: PASS");
    end else begin
      $display("row_centroid_of_marked_pixels_core_test: FAIL");
    end
    $finish;
  end

endmodule
